// ===== rtl/pclp_pkg.sv =====
// package for the pointing command line parser
// types, character codes and helper functions shared by every rtl file
`timescale 1ns / 1ps
`default_nettype none

package pclp_pkg;

  // sizes
  localparam int unsigned LineDepth  = 32;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned PosW       = 32;
  localparam int unsigned ScaleW     = 24;
  localparam int unsigned SetW       = 48;
  localparam int unsigned StepW      = 16;
  localparam int unsigned KindW      = 3;
  localparam int unsigned CfgIdxW    = 1;
  localparam int unsigned MagW       = 16;
  localparam int unsigned ValW       = 17;
  localparam int unsigned ProdW      = ValW + ScaleW + 1;

  localparam logic [MagW-1:0] MagSat = 16'h8000;
  localparam logic [MagW-1:0] PosSat = 16'h7fff;

  // character codes
  localparam logic [ByteW-1:0] CharColon = 8'h3a;
  localparam logic [ByteW-1:0] CharCr    = 8'h0d;
  localparam logic [ByteW-1:0] CharLf    = 8'h0a;
  localparam logic [ByteW-1:0] CharTab   = 8'h09;
  localparam logic [ByteW-1:0] CharVt    = 8'h0b;
  localparam logic [ByteW-1:0] CharFf    = 8'h0c;
  localparam logic [ByteW-1:0] CharSpace = 8'h20;
  localparam logic [ByteW-1:0] CharPlus  = 8'h2b;
  localparam logic [ByteW-1:0] CharMinus = 8'h2d;
  localparam logic [ByteW-1:0] CharZero  = 8'h30;
  localparam logic [ByteW-1:0] CharNine  = 8'h39;
  localparam logic [ByteW-1:0] CharZ     = 8'h5a;
  localparam logic [ByteW-1:0] CharE     = 8'h45;
  localparam logic [ByteW-1:0] CharT     = 8'h54;

  typedef enum logic [1:0] {
    CLS_DATA,
    CLS_COLON,
    CLS_CR
  } byte_class_e;

  typedef enum logic [KindW-1:0] {
    KIND_NONE    = 3'd0,
    KIND_AZ      = 3'd1,
    KIND_EL      = 3'd2,
    KIND_TOGGLE  = 3'd3,
    KIND_UNKNOWN = 3'd4
  } cmd_kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_AZ_SCALE = 1'b0,
    CFG_EL_SCALE = 1'b1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_SCAN,
    ST_MUL,
    ST_ADD,
    ST_EMIT
  } back_state_e;

  // one queued word
  typedef struct packed {
    byte_class_e             cls;
    logic [ByteW-1:0]        rx_byte;
    logic signed [PosW-1:0]  az_pos;
    logic signed [PosW-1:0]  el_pos;
  } item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic is_space(input logic [ByteW-1:0] c);
    logic r;
    case (c) inside
      CharSpace, CharTab, CharLf, CharVt, CharFf, CharCr: r = 1'b1;
      default:                                             r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= CharZero) && (c <= CharNine);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/pclp_front.sv =====
// front end: takes input words, classifies the byte and pushes into the queue
// depends on pclp_pkg
`timescale 1ns / 1ps
`default_nettype none

module pclp_front
  import pclp_pkg::*;
(
  input  wire logic                   in_valid_i,
  input  wire logic [ByteW-1:0]       rx_byte_i,
  input  wire logic signed [PosW-1:0] azimuth_position_i,
  input  wire logic signed [PosW-1:0] elevation_position_i,
  input  wire q_status_t              q_status_i,
  output logic                        in_stall_o,
  output logic                        push_o,
  output item_t                       item_o
);

  byte_class_e cls;

  always_comb begin
    unique case (rx_byte_i)
      CharColon: cls = CLS_COLON;
      CharCr:    cls = CLS_CR;
      default:   cls = CLS_DATA;
    endcase
  end

  assign in_stall_o = q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    item_o.cls     = cls;
    item_o.rx_byte = rx_byte_i;
    item_o.az_pos  = azimuth_position_i;
    item_o.el_pos  = elevation_position_i;
  end

endmodule

`default_nettype wire

// ===== rtl/pclp_queue.sv =====
// short word queue between front and back end
// depends on pclp_pkg
`timescale 1ns / 1ps
`default_nettype none

module pclp_queue
  import pclp_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  input  wire logic  pop_i,
  output item_t      item_o,
  output q_status_t  status_o
);

  localparam int unsigned QAW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCW = $clog2(QueueDepth + 1);
  localparam logic [QAW-1:0] LastSlot = QAW'(QueueDepth - 1);

  item_t          slot_q [QueueDepth];
  logic [QAW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QAW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCW-1:0] count_q, count_d;

  assign status_o.full  = (count_q == QCW'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign item_o         = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastSlot) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastSlot) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pclp_back.sv =====
// back end: line store, line scan and argument parse, setpoint math, result register
// depends on pclp_pkg
`timescale 1ns / 1ps
`default_nettype none

module pclp_back
  import pclp_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = LineDepth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire item_t                  q_item_i,
  input  wire q_status_t              q_status_i,
  output logic                        pop_o,
  input  wire logic [ScaleW-1:0]      az_scale_i,
  input  wire logic [ScaleW-1:0]      el_scale_i,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [ByteW-1:0]            echo_byte_o,
  output logic [KindW-1:0]            command_kind_o,
  output logic signed [SetW-1:0]      azimuth_setpoint_o,
  output logic signed [SetW-1:0]      elevation_setpoint_o,
  output logic [StepW-1:0]            azimuth_step_count_o,
  output logic [StepW-1:0]            elevation_step_count_o,
  output logic                        tracking_enabled_o
);

  localparam int unsigned AW = $clog2(LINE_DEPTH);
  localparam int unsigned IW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned PW = $clog2(LINE_DEPTH + 2);

  back_state_e state_q, state_d;

  // line store, no reset: only entries below the write index are used
  logic [ByteW-1:0] line_store_q [LINE_DEPTH];
  logic [ByteW-1:0] rd_data_q;
  logic [AW-1:0]    rd_addr;
  logic             mem_we;

  logic [IW-1:0]    widx_q, widx_d;
  logic [PW-1:0]    ptr_q, ptr_d;
  logic [PW-1:0]    cur_idx;
  item_t            item_q, item_d;
  logic             is_el_q, is_el_d;
  logic             neg_q, neg_d;
  logic             lead_done_q, lead_done_d;
  logic [MagW-1:0]  mag_q, mag_d;
  logic [MagW-1:0]  mag_next;
  logic [19:0]      mag_wide;
  logic signed [ProdW-1:0] prod_q, prod_d;
  logic [StepW-1:0] steps_q, steps_d;
  cmd_kind_e        kind_q, kind_d;

  logic signed [SetW-1:0] az_tgt_q, az_tgt_d;
  logic signed [SetW-1:0] el_tgt_q, el_tgt_d;
  logic [StepW-1:0]       az_steps_q, az_steps_d;
  logic [StepW-1:0]       el_steps_q, el_steps_d;
  logic                   track_q, track_d;

  logic                   out_valid_q, out_valid_d;
  logic [ByteW-1:0]       out_echo_q, out_echo_d;
  cmd_kind_e              out_kind_q, out_kind_d;
  logic signed [SetW-1:0] out_az_q, out_az_d;
  logic signed [SetW-1:0] out_el_q, out_el_d;
  logic [StepW-1:0]       out_az_steps_q, out_az_steps_d;
  logic [StepW-1:0]       out_el_steps_q, out_el_steps_d;
  logic                   out_track_q, out_track_d;

  logic pop;
  logic out_free;
  logic scan_end;
  logic scan_stop;
  logic ch_space, ch_digit, ch_sign;
  logic first_cmd;
  logic signed [ValW-1:0]   val_s;
  logic signed [ScaleW:0]   scale_s;
  logic [MagW-1:0]          mag_clip;
  logic signed [SetW-1:0]   sum48;
  logic signed [PosW-1:0]   pos_sel;

  assign pop      = (state_q == ST_IDLE) && !q_status_i.empty;
  assign pop_o    = pop;
  assign out_free = !out_valid_q || !out_stall_i;

  // scan bookkeeping: rd_data_q holds entry ptr_q - 1
  assign cur_idx   = ptr_q - 1'b1;
  assign scan_end  = (cur_idx >= PW'(widx_q));
  assign ch_space  = is_space(rd_data_q);
  assign ch_digit  = is_digit(rd_data_q);
  assign ch_sign   = (rd_data_q == CharPlus) || (rd_data_q == CharMinus);
  assign scan_stop = scan_end || (lead_done_q ? !ch_digit : !(ch_space || ch_sign || ch_digit));
  assign first_cmd = (rd_data_q == CharZ) || (rd_data_q == CharE);

  // mag * 10 + digit, saturated
  assign mag_wide = ({4'b0, mag_q} << 3) + ({4'b0, mag_q} << 1)
                  + {12'b0, rd_data_q - CharZero};
  assign mag_next = (mag_wide > {4'b0, MagSat}) ? MagSat : mag_wide[MagW-1:0];

  always_comb begin
    unique case (state_q)
      ST_SCAN: rd_addr = (ptr_q < PW'(LINE_DEPTH)) ? ptr_q[AW-1:0] : '0;
      ST_HEAD: rd_addr = AW'(1);
      default: rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_store_q[widx_q[AW-1:0]] <= q_item_i.rx_byte;
    end
    rd_data_q <= line_store_q[rd_addr];
  end

  // setpoint operands
  assign mag_clip = (mag_q > PosSat) ? PosSat : mag_q;
  assign val_s    = neg_q ? -$signed({1'b0, mag_q}) : $signed({1'b0, mag_clip});
  assign scale_s  = $signed({1'b0, (is_el_q ? el_scale_i : az_scale_i)});
  assign pos_sel  = is_el_q ? item_q.el_pos : item_q.az_pos;
  assign sum48    = SetW'({{(SetW - ProdW){prod_q[ProdW-1]}}, prod_q})
                  + SetW'({{(SetW - PosW){pos_sel[PosW-1]}}, pos_sel});

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          if (q_item_i.cls == CLS_CR && widx_q != '0) begin
            state_d = ST_HEAD;
          end else begin
            state_d = ST_EMIT;
          end
        end
      end
      ST_HEAD: state_d = first_cmd ? ST_SCAN : ST_EMIT;
      ST_SCAN: begin
        if (scan_stop) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_ADD;
      ST_ADD:  state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mem_we         = 1'b0;
    widx_d         = widx_q;
    ptr_d          = ptr_q;
    item_d         = item_q;
    is_el_d        = is_el_q;
    neg_d          = neg_q;
    lead_done_d    = lead_done_q;
    mag_d          = mag_q;
    prod_d         = prod_q;
    steps_d        = steps_q;
    kind_d         = kind_q;
    az_tgt_d       = az_tgt_q;
    el_tgt_d       = el_tgt_q;
    az_steps_d     = az_steps_q;
    el_steps_d     = el_steps_q;
    track_d        = track_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_echo_d     = out_echo_q;
    out_kind_d     = out_kind_q;
    out_az_d       = out_az_q;
    out_el_d       = out_el_q;
    out_az_steps_d = out_az_steps_q;
    out_el_steps_d = out_el_steps_q;
    out_track_d    = out_track_q;

    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          item_d = q_item_i;
          kind_d = KIND_NONE;
          unique case (q_item_i.cls)
            CLS_COLON: widx_d = '0;
            CLS_CR: begin
              if (widx_q == '0) begin
                kind_d = KIND_UNKNOWN;
              end
            end
            default: begin
              if (widx_q < IW'(LINE_DEPTH)) begin
                mem_we = 1'b1;
                widx_d = widx_q + 1'b1;
              end
            end
          endcase
        end
      end
      ST_HEAD: begin
        ptr_d       = PW'(2);
        neg_d       = 1'b0;
        lead_done_d = 1'b0;
        mag_d       = '0;
        unique case (rd_data_q)
          CharZ: is_el_d = 1'b0;
          CharE: is_el_d = 1'b1;
          CharT: begin
            track_d = !track_q;
            kind_d  = KIND_TOGGLE;
          end
          default: kind_d = KIND_UNKNOWN;
        endcase
      end
      ST_SCAN: begin
        ptr_d = ptr_q + 1'b1;
        if (!scan_end) begin
          if (lead_done_q) begin
            if (ch_digit) begin
              mag_d = mag_next;
            end
          end else if (ch_sign) begin
            neg_d       = (rd_data_q == CharMinus);
            lead_done_d = 1'b1;
          end else if (ch_digit) begin
            mag_d       = mag_next;
            lead_done_d = 1'b1;
          end
        end
      end
      ST_MUL: begin
        prod_d  = ProdW'(val_s * scale_s);
        steps_d = neg_q ? mag_q : mag_clip;
      end
      ST_ADD: begin
        if (is_el_q) begin
          el_tgt_d   = sum48;
          el_steps_d = steps_q;
          kind_d     = KIND_EL;
        end else begin
          az_tgt_d   = sum48;
          az_steps_d = steps_q;
          kind_d     = KIND_AZ;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_echo_d     = item_q.rx_byte;
          out_kind_d     = kind_q;
          out_az_d       = az_tgt_q;
          out_el_d       = el_tgt_q;
          out_az_steps_d = az_steps_q;
          out_el_steps_d = el_steps_q;
          out_track_d    = track_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      widx_q      <= '0;
      az_tgt_q    <= '0;
      el_tgt_q    <= '0;
      az_steps_q  <= '0;
      el_steps_q  <= '0;
      track_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      widx_q      <= widx_d;
      az_tgt_q    <= az_tgt_d;
      el_tgt_q    <= el_tgt_d;
      az_steps_q  <= az_steps_d;
      el_steps_q  <= el_steps_d;
      track_q     <= track_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q          <= ptr_d;
    item_q         <= item_d;
    is_el_q        <= is_el_d;
    neg_q          <= neg_d;
    lead_done_q    <= lead_done_d;
    mag_q          <= mag_d;
    prod_q         <= prod_d;
    steps_q        <= steps_d;
    kind_q         <= kind_d;
    out_echo_q     <= out_echo_d;
    out_kind_q     <= out_kind_d;
    out_az_q       <= out_az_d;
    out_el_q       <= out_el_d;
    out_az_steps_q <= out_az_steps_d;
    out_el_steps_q <= out_el_steps_d;
    out_track_q    <= out_track_d;
  end

  assign out_valid_o            = out_valid_q;
  assign echo_byte_o            = out_echo_q;
  assign command_kind_o         = out_kind_q;
  assign azimuth_setpoint_o     = out_az_q;
  assign elevation_setpoint_o   = out_el_q;
  assign azimuth_step_count_o   = out_az_steps_q;
  assign elevation_step_count_o = out_el_steps_q;
  assign tracking_enabled_o     = out_track_q;

endmodule

`default_nettype wire

// ===== rtl/pointing_command_line_parser_core.sv =====
// top level of the pointing command line parser: scale registers, front end,
// word queue and back end; depends on pclp_pkg, pclp_front, pclp_queue, pclp_back
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------------
//   in      | in        | in_valid_i / in_stall_o  | rx byte, azimuth and elevation position
//   out     | out       | out_valid_o / out_stall_i| echo, kind, setpoints, step counts, flag
//   cfg     | in        | cfg_valid_i / cfg_ready_o| register index, 24 bit scale
//
// timing: a byte that is not a carriage return passes the back end through queue pop
//   and result load; a line end with a Z or E command also passes the head read, the
//   parse scan over the stored bytes (at most LINE_DEPTH) on the one-read-per-cycle
//   line store, and the multiply and add steps; other line ends skip the scan and math
// reset: rst_ni clears control state, targets, step counts and the flag
// stalls: the two-word queue lets the input keep flowing while a result
//   waits on out_stall_i; in_stall_o rises only when the queue is full
`timescale 1ns / 1ps
`default_nettype none

module pointing_command_line_parser_core
  import pclp_pkg::*;
#(
  parameter int unsigned LINE_DEPTH = LineDepth
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // input words
  input  wire logic                   in_valid_i,
  output logic                        in_stall_o,
  input  wire logic [ByteW-1:0]       rx_byte_i,
  input  wire logic signed [PosW-1:0] azimuth_position_i,
  input  wire logic signed [PosW-1:0] elevation_position_i,
  // result words
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic [ByteW-1:0]            echo_byte_o,
  output logic [KindW-1:0]            command_kind_o,
  output logic signed [SetW-1:0]      azimuth_setpoint_o,
  output logic signed [SetW-1:0]      elevation_setpoint_o,
  output logic [StepW-1:0]            azimuth_step_count_o,
  output logic [StepW-1:0]            elevation_step_count_o,
  output logic                        tracking_enabled_o,
  // configuration writes
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [ScaleW-1:0]      cfg_data_i
);

  // scale registers, Q8.16 unsigned
  logic [ScaleW-1:0] az_scale_q, az_scale_d;
  logic [ScaleW-1:0] el_scale_q, el_scale_d;

  // front to queue
  logic      q_push;
  item_t     q_in_item;
  // queue to back
  logic      q_pop;
  item_t     q_out_item;
  q_status_t q_status;

  // the user must write config only while the block is idle; the block does not enforce it, so always ready
  assign cfg_ready_o = 1'b1;

  always_comb begin
    az_scale_d = az_scale_q;
    el_scale_d = el_scale_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_AZ_SCALE: az_scale_d = cfg_data_i;
        CFG_EL_SCALE: el_scale_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      az_scale_q <= '0;
      el_scale_q <= '0;
    end else begin
      az_scale_q <= az_scale_d;
      el_scale_q <= el_scale_d;
    end
  end

  // classify and enqueue
  pclp_front u_front (
    .in_valid_i           (in_valid_i),
    .rx_byte_i            (rx_byte_i),
    .azimuth_position_i   (azimuth_position_i),
    .elevation_position_i (elevation_position_i),
    .q_status_i           (q_status),
    .in_stall_o           (in_stall_o),
    .push_o               (q_push),
    .item_o               (q_in_item)
  );

  // decoupling queue
  pclp_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (q_push),
    .item_i   (q_in_item),
    .pop_i    (q_pop),
    .item_o   (q_out_item),
    .status_o (q_status)
  );

  // line store, parse and setpoint math
  pclp_back #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_back (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .q_item_i               (q_out_item),
    .q_status_i             (q_status),
    .pop_o                  (q_pop),
    .az_scale_i             (az_scale_q),
    .el_scale_i             (el_scale_q),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .echo_byte_o            (echo_byte_o),
    .command_kind_o         (command_kind_o),
    .azimuth_setpoint_o     (azimuth_setpoint_o),
    .elevation_setpoint_o   (elevation_setpoint_o),
    .azimuth_step_count_o   (azimuth_step_count_o),
    .elevation_step_count_o (elevation_step_count_o),
    .tracking_enabled_o     (tracking_enabled_o)
  );

  // queue never takes a word while full and never gives one while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_push |-> !q_status.full) and (q_pop |-> !q_status.empty))
    else $error("queue overflow or underflow");

  // only a carriage return can carry a command kind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (echo_byte_o != CharCr)) |-> (command_kind_o == KIND_NONE))
    else $error("command kind on a byte that is not a line end");

  // step counts never exceed the saturated magnitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((azimuth_step_count_o <= MagSat) && (elevation_step_count_o <= MagSat)))
    else $error("step count above saturation");

endmodule

`default_nettype wire

// ===== tb/tb_pointing_command_line_parser_core.sv =====
// self-checking testbench for pointing_command_line_parser_core: command line
// streams with random idling and stalls, checked word by word against a
// predictor of echo, kind, setpoints, step counts and tracking flag; needs pclp_pkg
`timescale 1ns / 1ps

module tb_pointing_command_line_parser_core;
  import pclp_pkg::*;

  // a carriage return walks at most the whole line store plus multiply and add
  localparam int DrainCycles = 2 * LineDepth + 16;

  // one result word as it leaves the block
  typedef struct packed {
    logic [ByteW-1:0]       echo;
    logic [KindW-1:0]       kind;
    logic signed [SetW-1:0] az_set;
    logic signed [SetW-1:0] el_set;
    logic [StepW-1:0]       az_steps;
    logic [StepW-1:0]       el_steps;
    logic                   tracking;
  } reply_t;

  // tracks the parser state, predicts one reply per accepted byte and checks
  // the replies in order
  class command_tracker;
    logic [ByteW-1:0]       line_buf[LineDepth];
    int                     widx = 0;
    logic signed [SetW-1:0] az_tgt = '0;
    logic signed [SetW-1:0] el_tgt = '0;
    logic [StepW-1:0]       az_steps = '0;
    logic [StepW-1:0]       el_steps = '0;
    logic                   tracking = 1'b0;
    logic [ScaleW-1:0]      az_scale = '0;
    logic [ScaleW-1:0]      el_scale = '0;
    reply_t                 replies_due[$];
    int                     errors = 0;
    int                     n_words = 0;
    int                     n_dropped = 0;
    int                     n_kind[5] = '{0, 0, 0, 0, 0};

    function void set_scale(cfg_reg_e idx, logic [ScaleW-1:0] value);
      case (idx)
        CFG_AZ_SCALE: az_scale = value;
        CFG_EL_SCALE: el_scale = value;
        default: ;
      endcase
    endfunction

    // argument after the command letter, atoi style, saturated to 16 bits
    function int parse_value();
      int  i = 1;
      int  mag = 0;
      bit  neg = 1'b0;
      while (i < widx && (line_buf[i] == CharSpace || line_buf[i] == CharTab ||
                          line_buf[i] == CharLf || line_buf[i] == CharVt ||
                          line_buf[i] == CharFf || line_buf[i] == CharCr))
        i++;
      if (i < widx && (line_buf[i] == CharPlus || line_buf[i] == CharMinus)) begin
        neg = (line_buf[i] == CharMinus);
        i++;
      end
      while (i < widx && line_buf[i] >= CharZero && line_buf[i] <= CharNine) begin
        mag = mag * 10 + (int'(line_buf[i]) - int'(CharZero));
        if (mag > int'(MagSat)) mag = int'(MagSat);
        i++;
      end
      if (neg) return -mag;
      return (mag > int'(PosSat)) ? int'(PosSat) : mag;
    endfunction

    // value times scale plus position, wrapped to the setpoint width
    function logic [SetW-1:0] aim(int value, logic [ScaleW-1:0] scale,
                                  logic signed [PosW-1:0] pos);
      longint prod;
      longint sum;
      prod = longint'(value) * longint'(scale);
      sum  = prod + longint'(pos);
      return sum[SetW-1:0];
    endfunction

    function void predict_word(logic [ByteW-1:0] b, logic signed [PosW-1:0] az_pos,
                               logic signed [PosW-1:0] el_pos);
      reply_t           r;
      cmd_kind_e        k;
      logic [ByteW-1:0] head;
      int               v;
      k = KIND_NONE;
      n_words++;
      if (b == CharColon) begin
        widx = 0;
      end else if (b == CharCr) begin
        head = (widx > 0) ? line_buf[0] : 8'h00;
        if (head == CharZ) begin
          v        = parse_value();
          az_tgt   = aim(v, az_scale, az_pos);
          az_steps = (v < 0) ? StepW'(-v) : StepW'(v);
          k        = KIND_AZ;
        end else if (head == CharE) begin
          v        = parse_value();
          el_tgt   = aim(v, el_scale, el_pos);
          el_steps = (v < 0) ? StepW'(-v) : StepW'(v);
          k        = KIND_EL;
        end else if (head == CharT) begin
          tracking = ~tracking;
          k        = KIND_TOGGLE;
        end else begin
          k = KIND_UNKNOWN;
        end
      end else if (widx < LineDepth) begin
        line_buf[widx] = b;
        widx++;
      end else begin
        n_dropped++;
      end
      n_kind[k]++;
      r.echo     = b;
      r.kind     = k;
      r.az_set   = az_tgt;
      r.el_set   = el_tgt;
      r.az_steps = az_steps;
      r.el_steps = el_steps;
      r.tracking = tracking;
      replies_due.push_back(r);
    endfunction

    function void cmp(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected 'h%0h, actual 'h%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (replies_due.size() == 0) begin
        $error("result word with no expected word waiting, echo 'h%0h", got.echo);
        errors++;
        return;
      end
      want = replies_due.pop_front();
      cmp("echo_byte", 64'(want.echo), 64'(got.echo));
      cmp("command_kind", 64'(want.kind), 64'(got.kind));
      cmp("azimuth_setpoint", 64'(unsigned'(want.az_set)), 64'(unsigned'(got.az_set)));
      cmp("elevation_setpoint", 64'(unsigned'(want.el_set)), 64'(unsigned'(got.el_set)));
      cmp("azimuth_step_count", 64'(want.az_steps), 64'(got.az_steps));
      cmp("elevation_step_count", 64'(want.el_steps), 64'(got.el_steps));
      cmp("tracking_enabled", 64'(want.tracking), 64'(got.tracking));
    endfunction

    function int words_due();
      return replies_due.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic [ByteW-1:0] rx_byte;
  logic signed [PosW-1:0] az_pos;
  logic signed [PosW-1:0] el_pos;
  logic out_stall;
  logic cfg_valid;
  logic [CfgIdxW-1:0] cfg_index;
  logic [ScaleW-1:0] cfg_data;

  logic in_stall;
  logic out_valid;
  logic [ByteW-1:0] echo_byte;
  logic [KindW-1:0] command_kind;
  logic signed [SetW-1:0] az_setpoint;
  logic signed [SetW-1:0] el_setpoint;
  logic [StepW-1:0] az_step_count;
  logic [StepW-1:0] el_step_count;
  logic tracking_enabled;
  logic cfg_ready;

  // no idling on either side while set
  bit calm = 1'b0;
  int n_cfg = 0;

  command_tracker tracker = new;

  pointing_command_line_parser_core i_dut (
    .clk_i                  (clk),
    .rst_ni                 (rst_n),
    .in_valid_i             (in_valid),
    .in_stall_o             (in_stall),
    .rx_byte_i              (rx_byte),
    .azimuth_position_i     (az_pos),
    .elevation_position_i   (el_pos),
    .out_valid_o            (out_valid),
    .out_stall_i            (out_stall),
    .echo_byte_o            (echo_byte),
    .command_kind_o         (command_kind),
    .azimuth_setpoint_o     (az_setpoint),
    .elevation_setpoint_o   (el_setpoint),
    .azimuth_step_count_o   (az_step_count),
    .elevation_step_count_o (el_step_count),
    .tracking_enabled_o     (tracking_enabled),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // receiver stalls at random, about ten percent of the time, unless calm
  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 10);
  end

  // result monitor: sampled at the edge, so values are the ones before it
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      tracker.check_reply('{echo: echo_byte, kind: command_kind, az_set: az_setpoint,
                            el_set: el_setpoint, az_steps: az_step_count,
                            el_steps: el_step_count, tracking: tracking_enabled});
    end
  end

  // positions lean on the extremes so the setpoint wrap gets exercised
  function automatic logic [PosW-1:0] pick_position();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '0;
      default: return $urandom;
    endcase
  endfunction

  // one word on the input channel; returns at the accepting edge with valid
  // still high, so the next word can follow without a gap
  task automatic send_word(logic [ByteW-1:0] b, logic [PosW-1:0] az,
                           logic [PosW-1:0] el);
    while (!calm && $urandom_range(0, 99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    az_pos   <= az;
    el_pos   <= el;
    do @(posedge clk); while (in_stall !== 1'b0);
    tracker.predict_word(b, az, el);
  endtask

  task automatic send_text(string s, logic [PosW-1:0] az, logic [PosW-1:0] el);
    for (int i = 0; i < s.len(); i++) send_word(s[i], az, el);
  endtask

  // scale writes only happen with the block idle
  task automatic write_scale(cfg_reg_e idx, logic [ScaleW-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    tracker.set_scale(idx, value);
    n_cfg++;
    @(posedge clk);
  endtask

  // hold off the sender until every expected word is back, then let the
  // back end run out
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.words_due() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // mostly well formed lines with random content, the rest noise or broken
  task automatic send_line();
    logic [ByteW-1:0] txt[$];
    logic [ByteW-1:0] blanks[5] = '{CharSpace, CharTab, CharLf, CharVt, CharFf};
    int               edges[6] = '{0, 1, 32767, 32768, 32769, 65535};
    string            num;
    int               pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      repeat ($urandom_range(1, 10)) txt.push_back(8'($urandom_range(0, 255)));
    end else begin
      // a line without the leading colon appends to whatever is stored
      if ($urandom_range(0, 9) != 0) txt.push_back(CharColon);
      pick = $urandom_range(0, 19);
      if (pick < 8) txt.push_back(CharZ);
      else if (pick < 15) txt.push_back(CharE);
      else if (pick < 17) txt.push_back(CharT);
      else if (pick < 19) txt.push_back(8'($urandom_range(33, 126)));
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) txt.push_back(blanks[$urandom_range(0, 4)]);
      case ($urandom_range(0, 3))
        1: txt.push_back(CharPlus);
        2: txt.push_back(CharMinus);
        default: ;
      endcase
      // long run of leading zeros can overflow the line store
      if ($urandom_range(0, 19) == 0)
        repeat ($urandom_range(20, 40)) txt.push_back(CharZero);
      pick = $urandom_range(0, 9);
      if (pick == 0) num = "";
      else if (pick == 1) num = $sformatf("%0d", edges[$urandom_range(0, 5)]);
      else if (pick < 4) num = $sformatf("%0d", $urandom_range(0, 99999));
      else num = $sformatf("%0d", $urandom_range(0, 999));
      for (int i = 0; i < num.len(); i++) txt.push_back(num[i]);
      if ($urandom_range(0, 9) == 0) txt.push_back(8'($urandom_range(33, 126)));
      txt.push_back(CharCr);
      // repeated line end reuses the same stored line
      if ($urandom_range(0, 19) == 0) txt.push_back(CharCr);
    end
    foreach (txt[i]) send_word(txt[i], pick_position(), pick_position());
  endtask

  task automatic random_words(int count);
    int start;
    start = tracker.n_words;
    while (tracker.n_words - start < count) send_line();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    rx_byte   = '0;
    az_pos    = '0;
    el_pos    = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_AZ_SCALE;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with the extreme scales; \015 is the carriage return
    write_scale(CFG_AZ_SCALE, 24'hff_ffff);
    write_scale(CFG_EL_SCALE, 24'h00_0000);
    send_text("\015", 32'h0, 32'h0);                             // empty line
    send_text("Z\t-99999\015", 32'h7fff_ffff, 32'h8000_0000);    // negative saturation
    send_text(":E+40000\015", 32'h7fff_ffff, 32'h8000_0000);     // positive saturation
    send_text(":T\015\015", 32'hffff_ffff, 32'h0000_0001);       // index kept, toggles back
    send_text(":Q7\015", 32'h0, 32'h0);                          // unknown letter
    random_words(380);
    settle();

    // opposite extremes, no idling on either side
    write_scale(CFG_AZ_SCALE, 24'h00_0000);
    write_scale(CFG_EL_SCALE, 24'hff_ffff);
    calm = 1'b1;
    random_words(400);
    calm = 1'b0;
    settle();

    write_scale(CFG_AZ_SCALE, 24'($urandom));
    write_scale(CFG_EL_SCALE, 24'($urandom));
    random_words(400);
    settle();

    // one degree per step on azimuth, tiny elevation scale
    write_scale(CFG_EL_SCALE, 24'h00_0001);
    write_scale(CFG_AZ_SCALE, 24'h01_0000);
    random_words(400);
    settle();

    $display("covered %0d words: %0d azimuth sets, %0d elevation sets,",
             tracker.n_words, tracker.n_kind[KIND_AZ], tracker.n_kind[KIND_EL]);
    $display("%0d toggles, %0d unknown lines, %0d bytes dropped at a full line store,",
             tracker.n_kind[KIND_TOGGLE], tracker.n_kind[KIND_UNKNOWN], tracker.n_dropped);
    $display("%0d scale writes", n_cfg);
    if (tracker.errors == 0 && tracker.words_due() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // watchdog, several times the slowest expected run
  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/pclp_pkg.sv
rtl/pclp_front.sv
rtl/pclp_queue.sv
rtl/pclp_back.sv
rtl/pointing_command_line_parser_core.sv
tb/tb_pointing_command_line_parser_core.sv
